[rtl/glfsr_pkg.sv]
`timescale 1ns / 1ps

package glfsr_pkg;

   localparam int STATE_BITS     = 1024;
   localparam int SEED_BITS      = 512;
   localparam int WORD_BITS      = 64;
   localparam int CELL_BITS      = 8;
   localparam int NUM_CELLS      = STATE_BITS / CELL_BITS;
   localparam int SEED_CELLS     = SEED_BITS / CELL_BITS;
   localparam int CELLS_PER_WORD = WORD_BITS / CELL_BITS;
   localparam int NUM_VARIANTS   = 16;
   localparam int VARIANT_BITS   = 4;
   localparam int MAX_TAPS       = 4;
   localparam int TAP_POS_BITS   = 6;
   localparam int LEN_BITS       = 11;
   // largest toggle position is 33, plus seven later shifts
   localparam int TOG_BITS       = 41;
   localparam int TOG_CELLS      = (TOG_BITS + CELL_BITS - 1) / CELL_BITS;

   localparam logic [2:0] LAST_WORD = 3'd7;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_GEN  = 1'b1
   } cmd_type;

   // tap_pos holds the toggle position N - tap
   typedef struct packed {
      logic [LEN_BITS-1:0]                      len;
      logic [MAX_TAPS-1:0]                      tap_en;
      logic [MAX_TAPS-1:0][TAP_POS_BITS-1:0]    tap_pos;
   } variant_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] out_byte;
      logic [TOG_BITS-1:0]  toggle;
   } fb_type;

   typedef struct packed {
      logic                 load_en;
      logic                 shift_en;
      logic [CELL_BITS-1:0] active;
   } cell_ctrl_type;

   function automatic variant_type variant_info(input logic [VARIANT_BITS-1:0] sel);
      variant_type v;
      unique case (sel)
         4'd0:  v = '{11'd1024, 4'b1111, {6'd23, 6'd22, 6'd9,  6'd0}};
         4'd1:  v = '{11'd777,  4'b1111, {6'd16, 6'd10, 6'd1,  6'd0}};
         4'd2:  v = '{11'd777,  4'b0011, {6'd0,  6'd0,  6'd29, 6'd0}};
         4'd3:  v = '{11'd667,  4'b1111, {6'd8,  6'd7,  6'd3,  6'd0}};
         4'd4:  v = '{11'd666,  4'b1111, {6'd10, 6'd7,  6'd2,  6'd0}};
         4'd5:  v = '{11'd665,  4'b1111, {6'd11, 6'd6,  6'd4,  6'd0}};
         4'd6:  v = '{11'd665,  4'b0011, {6'd0,  6'd0,  6'd33, 6'd0}};
         4'd7:  v = '{11'd512,  4'b1111, {6'd8,  6'd5,  6'd2,  6'd0}};
         4'd8:  v = '{11'd511,  4'b1111, {6'd10, 6'd8,  6'd2,  6'd0}};
         4'd9:  v = '{11'd511,  4'b0011, {6'd0,  6'd0,  6'd10, 6'd0}};
         4'd10: v = '{11'd444,  4'b1111, {6'd13, 6'd12, 6'd9,  6'd0}};
         4'd11: v = '{11'd333,  4'b1111, {6'd8,  6'd4,  6'd2,  6'd0}};
         4'd12: v = '{11'd333,  4'b0011, {6'd0,  6'd0,  6'd2,  6'd0}};
         4'd13: v = '{11'd303,  4'b1111, {6'd13, 6'd12, 6'd6,  6'd0}};
         4'd14: v = '{11'd256,  4'b1111, {6'd10, 6'd5,  6'd2,  6'd0}};
         default: v = '{11'd222, 4'b1111, {6'd8,  6'd5,  6'd2,  6'd0}};
      endcase
      return v;
   endfunction

endpackage

[rtl/glfsr_cell.sv]
`timescale 1ns / 1ps

module glfsr_cell
   import glfsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [CELL_BITS-1:0] load_byte,
   input  logic [CELL_BITS-1:0] prev_byte,
   input  logic [CELL_BITS-1:0] toggle_byte,
   output logic [CELL_BITS-1:0] cell_byte
);

   logic [CELL_BITS-1:0] bits_ff;
   logic [CELL_BITS-1:0] bits_in;

   // a generate word moves the whole register up by eight, one cell per word;
   // bits at or above the active length hold
   always_comb begin
      bits_in = bits_ff;
      if (ctrl.load_en) begin
         bits_in = load_byte;
      end else if (ctrl.shift_en) begin
         bits_in = (ctrl.active & (prev_byte ^ toggle_byte)) | (~ctrl.active & bits_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   assign cell_byte = bits_ff;

endmodule

[rtl/glfsr_feedback.sv]
`timescale 1ns / 1ps

module glfsr_feedback
   import glfsr_pkg::*;
(
   input  logic [STATE_BITS-1:0]   state,
   input  logic [VARIANT_BITS-1:0] variant,
   output fb_type                  fb
);

   variant_type vinfo;

   assign vinfo = variant_info(variant);

   // toggles stay far below N-8, so the eight output bits are just the top
   // eight bits of the active length, first out in bit 7
   always_comb begin
      variant_type vv;
      fb = '0;
      for (int v = 0; v < NUM_VARIANTS; v++) begin
         vv = variant_info(VARIANT_BITS'(v));
         if (variant == VARIANT_BITS'(v)) begin
            fb.out_byte = state[int'(vv.len) - CELL_BITS +: CELL_BITS];
         end
      end
      // output bit k toggles position p, which then rides 7-k more shifts:
      // each tap contributes the output byte shifted up by p
      for (int t = 0; t < MAX_TAPS; t++) begin
         if (vinfo.tap_en[t]) begin
            fb.toggle = fb.toggle ^ (TOG_BITS'(fb.out_byte) << vinfo.tap_pos[t]);
         end
      end
   end

endmodule

[rtl/galois_lfsr_byte_generator.sv]
`timescale 1ns / 1ps

// Galois LFSR byte generator, up to 1024 bits, 16 built-in length/tap variants.
// Request channel (req_valid/req_ready): req_command selects load or generate.
//   Load writes one 64-bit digest word (req_word_index, req_seed_word) into both
//   halves of the register; loading word 7 also takes the variant from its low
//   four bits. A load word returns nothing.
//   Generate performs eight shifts at once and returns one byte.
// Response channel (rsp_valid/rsp_ready): rsp_random_byte, first shifted-out bit
//   in bit 7, registered; it appears the cycle after the request is taken.
// Throughput: one request word per cycle while no response is stalled. The register
//   is a row of 128 eight-bit cells, each taking its lower neighbor's byte on a
//   generate word, so the eight shifts happen together.
// Stall: while a byte waits with rsp_ready low, req_ready drops; a request can
//   enter in the same cycle the waiting byte is taken.
// Reset: the register clears to zero and variant 0 (length 1024) is selected;
//   generating before any load yields zero bytes.

module galois_lfsr_byte_generator
   import glfsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [2:0]  req_word_index,
   input  logic [63:0] req_seed_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_random_byte
);

   logic                    req_fire;
   logic                    load_fire;
   logic                    gen_fire;
   logic [STATE_BITS-1:0]   state;
   variant_type             cur_info;
   logic [LEN_BITS-1:0]     cur_len;
   logic [TOG_CELLS*CELL_BITS-1:0] tog_ext;
   fb_type                  fb;

   logic [VARIANT_BITS-1:0] variant_ff;
   logic [VARIANT_BITS-1:0] variant_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [7:0]              rsp_byte_ff;
   logic [7:0]              rsp_byte_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_command == CMD_LOAD);
   assign gen_fire  = req_fire && (req_command == CMD_GEN);
   assign cur_info  = variant_info(variant_ff);
   assign cur_len   = cur_info.len;
   assign tog_ext   = (TOG_CELLS*CELL_BITS)'(fb.toggle);

   glfsr_feedback u_feedback (
      .state   (state),
      .variant (variant_ff),
      .fb      (fb)
   );

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      localparam int SLOT = (c % SEED_CELLS) / CELLS_PER_WORD;
      localparam int J    = (c % SEED_CELLS) % CELLS_PER_WORD;

      cell_ctrl_type        ctrl;
      logic [CELL_BITS-1:0] load_byte;
      logic [CELL_BITS-1:0] prev_byte;
      logic [CELL_BITS-1:0] toggle_byte;

      assign ctrl.load_en  = load_fire && (req_word_index == 3'(SLOT));
      assign ctrl.shift_en = gen_fire;

      // digest bits run from bit 63 downward within the word
      for (genvar m = 0; m < CELL_BITS; m++) begin : g_bit
         assign load_byte[m]   = req_seed_word[WORD_BITS - 1 - CELL_BITS*J - m];
         assign ctrl.active[m] = LEN_BITS'(c*CELL_BITS + m) < cur_len;
      end

      if (c == 0) begin : g_first
         assign prev_byte = '0;
      end else begin : g_rest
         assign prev_byte = state[(c-1)*CELL_BITS +: CELL_BITS];
      end

      if (c < TOG_CELLS) begin : g_tog
         assign toggle_byte = tog_ext[c*CELL_BITS +: CELL_BITS];
      end else begin : g_notog
         assign toggle_byte = '0;
      end

      glfsr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .load_byte   (load_byte),
         .prev_byte   (prev_byte),
         .toggle_byte (toggle_byte),
         .cell_byte   (state[c*CELL_BITS +: CELL_BITS])
      );
   end

   always_comb begin
      variant_in = variant_ff;
      if (load_fire && (req_word_index == LAST_WORD)) begin
         variant_in = req_seed_word[VARIANT_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      if (gen_fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = fb.out_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         variant_ff   <= variant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_byte = rsp_byte_ff;

   a_gen_gives_word: assert property (@(posedge clock) disable iff (reset)
      gen_fire |=> rsp_valid)
      else $error("generate word produced no response");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (load_fire && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid)
      else $error("load word produced a response");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("request side blocked without a stalled response");

   // every variant toggles position zero, so the feedback's lowest bit is the last output
   a_feedback_tap0: assert property (@(posedge clock) disable iff (reset)
      fb.toggle[0] == fb.out_byte[0])
      else $error("feedback lost the position-zero tap");

endmodule
